[rtl/congruential_random_generator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the congruential generator core
// Concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef CONGRUENTIAL_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define CONGRUENTIAL_RANDOM_GENERATOR_CORE_ASSERT_SVH

// checked only while out of reset
`define LCG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked at every edge, reset included
`define LCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/lcg_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants of the congruential generator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcg_pkg;

  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_INCREMENT  = 2'd1,
    REG_MODULUS    = 2'd2,
    REG_SEED       = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] MULTIPLIER_RST = 32'd221;
  localparam logic [CFG_W-1:0] INCREMENT_RST  = 32'd0;
  localparam logic [CFG_W-1:0] MODULUS_RST    = 32'd10000;
  localparam logic [CFG_W-1:0] SEED_RST       = 32'd1324;

  typedef struct packed {
    logic [CFG_W-1:0] multiplier;
    logic [CFG_W-1:0] increment;
    logic [CFG_W-1:0] modulus;
    logic [CFG_W-1:0] seed;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_REDUCE,
    ST_WRITE
  } lcg_state_e;

  typedef struct packed {
    logic load;    // capture start value
    logic mult;    // form a*x + c
    logic step;    // two reduction bits
    logic write;   // commit state and output
  } lcg_cmd_t;

  typedef struct packed {
    logic mod_zero;
  } lcg_status_t;

endpackage

[rtl/congruential_random_generator_core.sv]
// ----------------------------------------------------------------------------
// congruential_random_generator_core
// Linear congruential generator, x <= (a*x + c) mod m, one value per request.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: reseed
//  m_axis    out  tdata: value
//  cfg       in   index 0 multiplier, 1 increment, 2 modulus, 3 seed
//
//  A request runs from accept to the next accept through a multiply step,
//  then the modulo reduction at two quotient bits per cycle over the
//  2*STATE_WIDTH-bit sum, then a commit.
//  Modulus zero skips the reduction (STATE_WIDTH-wide wrap).
//  Reset loads the seed reset value into the state; no clearing pass.
//  A stalled result holds in the output register; a finished request waits
//  for that register to free before it commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module congruential_random_generator_core
  import lcg_pkg::*;
#(
  parameter int unsigned STATE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [0] reseed, rest zero
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] value
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  cfg_t        cfg;
  lcg_cmd_t    cmd;
  lcg_status_t status;

  lcg_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  lcg_ctrl #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcg_datapath #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .reseed_i (s_axis_tdata_i[0]),
    .status_o (status),
    .value_o  (m_axis_tdata_o)
  );

endmodule

[rtl/lcg_regs.sv]
// ----------------------------------------------------------------------------
// lcg_regs
// Configuration register file: multiplier, increment, modulus, seed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_regs
  import lcg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [CFG_W-1:0]     data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        REG_MULTIPLIER: cfg_d.multiplier = data_i;
        REG_INCREMENT:  cfg_d.increment  = data_i;
        REG_MODULUS:    cfg_d.modulus    = data_i;
        REG_SEED:       cfg_d.seed       = data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.multiplier <= MULTIPLIER_RST;
      cfg_q.increment  <= INCREMENT_RST;
      cfg_q.modulus    <= MODULUS_RST;
      cfg_q.seed       <= SEED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/lcg_ctrl.sv]
// ----------------------------------------------------------------------------
// lcg_ctrl
// Sequencer: multiply, reduce two bits per cycle, commit, output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "congruential_random_generator_core_assert.svh"

module lcg_ctrl
  import lcg_pkg::*;
#(
  parameter int unsigned STATE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  lcg_status_t status_i,
  output lcg_cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(STATE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_WIDTH - 1);

  lcg_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last;
  logic             accept;
  logic             commit;

  assign last   = (cnt_q == CNT_LAST);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign commit = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MULT;
      ST_MULT:   state_d = status_i.mod_zero ? ST_WRITE : ST_REDUCE;
      ST_REDUCE: if (last) state_d = ST_WRITE;
      ST_WRITE:  if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept;
    cmd_o.mult  = (state_q == ST_MULT);
    cmd_o.step  = (state_q == ST_REDUCE);
    cmd_o.write = commit;
    in_ready_o  = (state_q == ST_IDLE);
    cnt_d       = cnt_q;
    if (state_q == ST_REDUCE) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LCG_ASSERT(a_cnt_only_reducing, clk_i, rst_ni, (cnt_q != '0) |-> (state_q == ST_REDUCE), "step count live outside reduction")
  `LCG_ASSERT(a_accept_to_mult, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == ST_MULT), "accepted request did not start multiply")
  `LCG_ASSERT(a_commit_shows_result, clk_i, rst_ni, commit |=> (out_valid_q && (state_q == ST_IDLE)), "committed result not presented")

endmodule

[rtl/lcg_datapath.sv]
// ----------------------------------------------------------------------------
// lcg_datapath
// State register, a*x + c product and restoring modulo reduction, radix 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_datapath
  import lcg_pkg::*;
#(
  parameter int unsigned STATE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  lcg_cmd_t               cmd_i,
  input  logic                   reseed_i,
  output lcg_status_t            status_o,
  output logic [OUT_TDATA_W-1:0] value_o
);

  localparam int unsigned W  = STATE_WIDTH;
  localparam int unsigned PW = 2 * STATE_WIDTH;
  localparam logic [W-1:0] STATE_RST = SEED_RST[W-1:0];

  logic [W-1:0]  a_w, c_w, m_w, seed_w;
  logic [W-1:0]  state_q;
  logic [W-1:0]  x_q;
  logic [PW-1:0] prod_q, prod_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  result;
  logic [OUT_TDATA_W-1:0] out_q;

  assign a_w    = cfg_i.multiplier[W-1:0];
  assign c_w    = cfg_i.increment[W-1:0];
  assign m_w    = cfg_i.modulus[W-1:0];
  assign seed_w = cfg_i.seed[W-1:0];

  assign status_o.mod_zero = (m_w == '0);

  always_comb begin
    logic [W:0] r1;
    logic [W:0] r2;
    r1 = {rem_q, prod_q[PW-1]};
    if (r1 >= {1'b0, m_w}) r1 = r1 - {1'b0, m_w};
    r2 = {r1[W-1:0], prod_q[PW-2]};
    if (r2 >= {1'b0, m_w}) r2 = r2 - {1'b0, m_w};
    prod_d = prod_q;
    rem_d  = rem_q;
    if (cmd_i.mult) begin
      prod_d = PW'(a_w) * PW'(x_q) + PW'(c_w);
      rem_d  = '0;
    end else if (cmd_i.step) begin
      prod_d = {prod_q[PW-3:0], 2'b00};
      rem_d  = r2[W-1:0];
    end
  end

  assign result = status_o.mod_zero ? prod_q[W-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (cmd_i.write) begin
      state_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= reseed_i ? seed_w : state_q;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    if (cmd_i.write) out_q <= OUT_TDATA_W'(result);
  end

  assign value_o = out_q;

endmodule
